// ===== rtl/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg
// shared types, sizes and constant tables of the longwave solver
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int NUM_ANGLES = 20;
  localparam int MAX_LAYERS = 63;
  localparam int ANG_W      = 5;
  localparam int LEV_W      = 6;
  localparam int OUT_LEV_W  = 7;
  localparam int SUM_W      = 41;

  localparam logic [17:0] PI_Q16  = 18'd205887;
  localparam logic [9:0]  DIV25_M = 10'(((32'd1 << 14) + 32'd24) / 32'd25);
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic [23:0] tau;
    logic [31:0] src;
    logic [31:0] bs;
    logic        bottom;
  } layer_t;

  typedef struct packed {
    logic             dir_up;
    logic [LEV_W-1:0] lev;
  } tag_t;

  typedef struct packed {
    logic [ANG_W-1:0] idx;
    logic             last;
    logic             first;
    tag_t             tag;
    logic [31:0]      src;
  } ang_t;

  // ceil(2^31 / (2i+1))
  localparam logic [31:0] RECIP [NUM_ANGLES] = '{
    32'(((64'd1 << 31) + 64'd0)  / 64'd1),  32'(((64'd1 << 31) + 64'd2)  / 64'd3),
    32'(((64'd1 << 31) + 64'd4)  / 64'd5),  32'(((64'd1 << 31) + 64'd6)  / 64'd7),
    32'(((64'd1 << 31) + 64'd8)  / 64'd9),  32'(((64'd1 << 31) + 64'd10) / 64'd11),
    32'(((64'd1 << 31) + 64'd12) / 64'd13), 32'(((64'd1 << 31) + 64'd14) / 64'd15),
    32'(((64'd1 << 31) + 64'd16) / 64'd17), 32'(((64'd1 << 31) + 64'd18) / 64'd19),
    32'(((64'd1 << 31) + 64'd20) / 64'd21), 32'(((64'd1 << 31) + 64'd22) / 64'd23),
    32'(((64'd1 << 31) + 64'd24) / 64'd25), 32'(((64'd1 << 31) + 64'd26) / 64'd27),
    32'(((64'd1 << 31) + 64'd28) / 64'd29), 32'(((64'd1 << 31) + 64'd30) / 64'd31),
    32'(((64'd1 << 31) + 64'd32) / 64'd33), 32'(((64'd1 << 31) + 64'd34) / 64'd35),
    32'(((64'd1 << 31) + 64'd36) / 64'd37), 32'(((64'd1 << 31) + 64'd38) / 64'd39)
  };

  // ceil(2^21 / k), k = 1..8
  localparam logic [21:0] MK [8] = '{
    22'(((32'd1 << 21) + 32'd0) / 32'd1), 22'(((32'd1 << 21) + 32'd1) / 32'd2),
    22'(((32'd1 << 21) + 32'd2) / 32'd3), 22'(((32'd1 << 21) + 32'd3) / 32'd4),
    22'(((32'd1 << 21) + 32'd4) / 32'd5), 22'(((32'd1 << 21) + 32'd5) / 32'd6),
    22'(((32'd1 << 21) + 32'd6) / 32'd7), 22'(((32'd1 << 21) + 32'd7) / 32'd8)
  };

  // round(e^-n) in q1.16, unused codes zero
  localparam logic [16:0] ENEG [16] = '{
    17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442,
    17'd162, 17'd60, 17'd22, 17'd8, 17'd3, 17'd1, 17'd0, 17'd0, 17'd0, 17'd0
  };

endpackage

// ===== rtl/longwave_schwarzschild_solver.sv =====
// ----------------------------------------------------------------------------
// longwave_schwarzschild_solver
// discrete-angle schwarzschild solver: layers in top to bottom, level fluxes
// out bottom to top after the lowest layer
// ----------------------------------------------------------------------------
// a layer issues its angles to the shared angle pipeline (one angle a cycle);
// its radiances settle after the transmittance and blend stages, its flux after
// the flux divider; a bottom layer waits for the pipeline to drain, then the
// upward sweep gives one result per level, bottom level first, top level last
// busy rises only while the two-entry command queue is full
// synchronous reset clears the queue, the sequencers and the column state
module longwave_schwarzschild_solver (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] layer_tau,
  input  logic [31:0] layer_source,
  input  logic [31:0] surface_source,
  input  logic        bottom,
  output logic        strobe,
  output logic [6:0]  level,
  output logic [31:0] down_flux,
  output logic [31:0] up_flux,
  output logic        final_level,
  output logic        overflow
);
  import lss_pkg::*;

  layer_t in_item;
  layer_t q_item;
  logic   q_valid;
  logic   q_pop;

  assign in_item.tau    = layer_tau;
  assign in_item.src    = layer_source;
  assign in_item.bs     = surface_source;
  assign in_item.bottom = bottom;

  lss_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  lss_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .strobe      (strobe),
    .level       (level),
    .down_flux   (down_flux),
    .up_flux     (up_flux),
    .final_level (final_level),
    .overflow    (overflow)
  );

endmodule

// ===== rtl/lss_front.sv =====
// ----------------------------------------------------------------------------
// lss_front
// accepts layer commands into a two-entry queue ahead of the solver core
// ----------------------------------------------------------------------------
module lss_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  lss_pkg::layer_t in_item,
  output logic            q_valid,
  output lss_pkg::layer_t q_item,
  input  logic            q_pop
);
  import lss_pkg::*;

  layer_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;

  assign busy    = (fill == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (fill != 2'd0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== rtl/lss_xmit.sv =====
// ----------------------------------------------------------------------------
// lss_xmit
// transmittance pipeline: one angle per cycle, tau/mu then exp(-x) by horner
// ----------------------------------------------------------------------------
module lss_xmit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [23:0]   in_tau,
  input  lss_pkg::ang_t in_ang,
  output logic          out_valid,
  output logic [16:0]   out_t,
  output lss_pkg::ang_t out_ang,
  output logic          any_valid
);
  import lss_pkg::*;

  typedef struct packed {
    ang_t        ang;
    logic        sat;
    logic [3:0]  n;
    logic [15:0] f;
  } hs_t;

  logic        v0;
  logic [24:0] n0;
  logic        sat0;
  ang_t        ang0;
  logic [29:0] tau40;
  logic [25:0] lim;
  logic [56:0] xprod;

  logic        hv_b [9];
  hs_t         hs_b [9];
  logic [16:0] p_b  [9];
  logic        hv_a [8];
  hs_t         hs_a [8];
  logic [16:0] v_a  [8];

  logic [32:0] tprod;
  logic [8:0]  vmask;

  assign tau40 = (30'(in_tau) << 5) + (30'(in_tau) << 3);
  assign lim   = (26'({in_ang.idx, 1'b1}) * 26'd3) << 18;

  always_ff @(posedge clk) begin
    n0   <= tau40[24:0];
    sat0 <= (tau40 >= 30'(lim));
    ang0 <= in_ang;
  end

  assign xprod = 57'(n0) * 57'(RECIP[ang0.idx]);

  always_ff @(posedge clk) begin
    hs_b[0].ang <= ang0;
    hs_b[0].sat <= sat0;
    hs_b[0].n   <= xprod[50:47];
    hs_b[0].f   <= xprod[46:31];
    p_b[0]      <= ONE_Q16;
  end

  for (genvar j = 0; j < 8; j++) begin : g_horner
    logic [32:0] fp;
    logic [38:0] vq;
    assign fp = 33'(hs_b[j].f) * 33'(p_b[j]);
    assign vq = 39'(v_a[j]) * 39'(MK[7-j]);
    always_ff @(posedge clk) begin
      hs_a[j]   <= hs_b[j];
      v_a[j]    <= fp[32:16];
      hs_b[j+1] <= hs_a[j];
      p_b[j+1]  <= ONE_Q16 - vq[37:21];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        hv_a[j]   <= 1'b0;
        hv_b[j+1] <= 1'b0;
      end else begin
        hv_a[j]   <= hv_b[j];
        hv_b[j+1] <= hv_a[j];
      end
    end
  end

  assign tprod = 33'(ENEG[hs_b[8].n]) * 33'(p_b[8]) + 33'd32768;

  always_ff @(posedge clk) begin
    out_t   <= hs_b[8].sat ? 17'd0 : tprod[32:16];
    out_ang <= hs_b[8].ang;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      hv_b[0]   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v0        <= in_valid;
      hv_b[0]   <= v0;
      out_valid <= hv_b[8];
    end
  end

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      vmask[j] = hv_b[j] || ((j < 8) ? hv_a[j % 8] : 1'b0);
    end
  end

  assign any_valid = v0 || (|vmask) || out_valid;

endmodule

// ===== rtl/lss_flux.sv =====
// ----------------------------------------------------------------------------
// lss_flux
// flux from a weighted radiance sum: times pi, divided by 400, rounded
// ----------------------------------------------------------------------------
module lss_flux (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lss_pkg::SUM_W-1:0]  sum,
  input  lss_pkg::tag_t              tag_in,
  output logic                       busy,
  output logic                       done,
  output logic [31:0]                value,
  output lss_pkg::tag_t              tag_out
);
  import lss_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL0 = 5'b00010,
    F_MUL1 = 5'b00100,
    F_DIV  = 5'b01000,
    F_OUT  = 5'b10000
  } fstate_t;

  fstate_t          state;
  logic [SUM_W-1:0] sreg;
  logic [58:0]      acc;
  logic [55:0]      dvd;
  logic [55:0]      quo;
  logic [4:0]       rem;
  logic [3:0]       steps;
  logic [8:0]       cur;
  logic [18:0]      qprod;
  logic [3:0]       qdig;
  logic [56:0]      rnd;

  assign cur   = {rem, dvd[55:52]};
  assign qprod = 19'(cur) * 19'(DIV25_M);
  assign qdig  = qprod[17:14];
  assign rnd   = 57'(quo) + 57'd32768;
  assign busy  = (state != F_IDLE);

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        sreg    <= sum;
        tag_out <= tag_in;
      end
      F_MUL0: acc <= 59'(sreg[20:0]) * 59'(PI_Q16);
      F_MUL1: begin
        dvd <= 56'((acc + ((59'(sreg[40:21]) * 59'(PI_Q16)) << 21)) >> 4);
        rem <= 5'd0;
      end
      F_DIV: begin
        dvd <= dvd << 4;
        quo <= {quo[51:0], qdig};
        rem <= 5'(cur - 9'(qdig) * 9'd25);
      end
      F_OUT: value <= (|rnd[56:48]) ? 32'hFFFF_FFFF : rnd[47:16];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      steps <= 4'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        F_IDLE: if (start) state <= F_MUL0;
        F_MUL0: state <= F_MUL1;
        F_MUL1: begin
          state <= F_DIV;
          steps <= 4'd0;
        end
        F_DIV: begin
          steps <= steps + 4'd1;
          if (steps == 4'd13) state <= F_OUT;
        end
        F_OUT: begin
          state <= F_IDLE;
          done  <= 1'b1;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/lss_back.sv =====
// ----------------------------------------------------------------------------
// lss_back
// solver core: downward layer passes, upward sweep and level results
// ----------------------------------------------------------------------------
module lss_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  lss_pkg::layer_t               q_item,
  output logic                          q_pop,
  output logic                          strobe,
  output logic [lss_pkg::OUT_LEV_W-1:0] level,
  output logic [31:0]                   down_flux,
  output logic [31:0]                   up_flux,
  output logic                          final_level,
  output logic                          overflow
);
  import lss_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DOWN  = 6'b000010,
    S_DRAIN = 6'b000100,
    S_READ  = 6'b001000,
    S_UP    = 6'b010000,
    S_TAIL  = 6'b100000
  } state_t;

  state_t           state;
  logic [LEV_W-1:0] cnt;
  logic             dropped;
  logic [31:0]      bs_reg;
  logic             col_end;
  logic [ANG_W-1:0] ang;
  logic [23:0]      p_tau;
  logic [31:0]      p_src;
  logic [LEV_W-1:0] p_lev;
  logic             p_first;
  logic [LEV_W-1:0] lev;

  logic [23:0]      mem_tau [MAX_LAYERS];
  logic [31:0]      mem_src [MAX_LAYERS];
  logic [31:0]      mem_dflux [MAX_LAYERS + 1];
  logic [23:0]      tau_q;
  logic [31:0]      src_q;
  logic [31:0]      dflux_q;
  logic [LEV_W-1:0] dflux_addr;

  logic             iss_valid;
  logic [23:0]      iss_tau;
  ang_t             iss_ang;
  logic             x_valid;
  logic [16:0]      x_t;
  ang_t             x_ang;
  logic             x_any;

  logic [31:0]      rad [NUM_ANGLES];
  logic [31:0]      old;
  logic             m_v;
  ang_t             m_ang;
  logic [48:0]      m1;
  logic [48:0]      m2;
  logic             w_v;
  ang_t             w_ang;
  logic [49:0]      wsum;
  logic [31:0]      lnew;
  logic [37:0]      wprod;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] acc_next;

  logic             f_start;
  logic             f_busy;
  logic             f_done;
  logic [31:0]      f_value;
  tag_t             f_tag;

  logic [49:0]      pibs_q;
  logic [34:0]      pibs_rnd;
  logic             em_pend;
  logic [LEV_W-1:0] em_lev;
  logic [31:0]      em_up;
  logic             all_idle;
  logic             can_store;

  assign can_store = (cnt != LEV_W'(MAX_LAYERS));
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign all_idle  = !x_any && !m_v && !w_v && !f_busy && !f_done && !em_pend;

  // issue
  assign iss_valid     = (state == S_DOWN) || (state == S_UP);
  assign iss_tau       = (state == S_UP) ? tau_q : p_tau;
  assign iss_ang.idx   = ang;
  assign iss_ang.last  = (ang == ANG_W'(NUM_ANGLES - 1));
  assign iss_ang.first = (state == S_UP) ? (lev == LEV_W'(cnt - LEV_W'(1))) : p_first;
  assign iss_ang.tag   = (state == S_UP) ? tag_t'{dir_up: 1'b1, lev: lev}
                                         : tag_t'{dir_up: 1'b0, lev: p_lev};
  assign iss_ang.src   = (state == S_UP) ? src_q : p_src;

  lss_xmit u_xmit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (iss_valid),
    .in_tau    (iss_tau),
    .in_ang    (iss_ang),
    .out_valid (x_valid),
    .out_t     (x_t),
    .out_ang   (x_ang),
    .any_valid (x_any)
  );

  // blend
  assign old = x_ang.first ? (x_ang.tag.dir_up ? bs_reg : 32'd0) : rad[x_ang.idx];

  always_ff @(posedge clk) begin
    m_ang <= x_ang;
    m1    <= 49'(x_t) * 49'(old);
    m2    <= 49'(ONE_Q16 - x_t) * 49'(x_ang.src);
    w_ang <= m_ang;
    lnew  <= wsum[47:16];
    if (m_v) begin
      rad[m_ang.idx] <= wsum[47:16];
    end
    if (w_v) begin
      acc <= acc_next;
    end
  end

  assign wsum     = 50'(m1) + 50'(m2) + 50'd32768;
  assign wprod    = 38'(lnew) * 38'({w_ang.idx, 1'b1});
  assign acc_next = ((w_ang.idx == '0) ? '0 : acc) + SUM_W'(wprod);
  assign f_start  = w_v && w_ang.last;

  lss_flux u_flux (
    .clk     (clk),
    .rst     (rst),
    .start   (f_start),
    .sum     (acc_next),
    .tag_in  (w_ang.tag),
    .busy    (f_busy),
    .done    (f_done),
    .value   (f_value),
    .tag_out (f_tag)
  );

  // stores
  assign dflux_addr = (state == S_DRAIN) ? cnt : f_tag.lev;

  always_ff @(posedge clk) begin
    if (q_pop && can_store) begin
      mem_tau[cnt] <= q_item.tau;
      mem_src[cnt] <= q_item.src;
    end
    tau_q <= mem_tau[lev];
    src_q <= mem_src[lev];
    if (f_done && !f_tag.dir_up) begin
      mem_dflux[f_tag.lev] <= f_value;
    end
    dflux_q <= mem_dflux[dflux_addr];
    if (q_pop) begin
      pibs_q <= 50'(q_item.bs) * 50'(PI_Q16);
    end
  end

  assign pibs_rnd = 35'(pibs_q[49:16]) + 35'(pibs_q[15]);

  // results
  assign strobe      = em_pend;
  assign level       = OUT_LEV_W'(em_lev);
  assign down_flux   = (em_lev == '0) ? 32'd0 : dflux_q;
  assign up_flux     = em_up;
  assign final_level = (em_lev == '0);
  assign overflow    = dropped;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p_tau   <= q_item.tau;
      p_src   <= q_item.src;
      p_lev   <= cnt + LEV_W'(1);
      p_first <= (cnt == '0);
      col_end <= q_item.bottom;
      bs_reg  <= q_item.bs;
    end
    if (f_done) begin
      em_lev <= f_tag.lev;
      em_up  <= f_value;
    end else if (state == S_DRAIN) begin
      em_lev <= cnt;
      em_up  <= (|pibs_rnd[34:32]) ? 32'hFFFF_FFFF : pibs_rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      dropped <= 1'b0;
      ang     <= '0;
      lev     <= '0;
      m_v     <= 1'b0;
      w_v     <= 1'b0;
      em_pend <= 1'b0;
    end else begin
      m_v     <= x_valid;
      w_v     <= m_v;
      em_pend <= (f_done && f_tag.dir_up) || ((state == S_DRAIN) && all_idle);
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            ang <= '0;
            if (can_store) begin
              cnt   <= cnt + LEV_W'(1);
              state <= S_DOWN;
            end else begin
              dropped <= 1'b1;
              if (q_item.bottom) state <= S_DRAIN;
            end
          end
        end
        S_DOWN: begin
          ang <= ang + ANG_W'(1);
          if (ang == ANG_W'(NUM_ANGLES - 1)) begin
            state <= col_end ? S_DRAIN : S_IDLE;
          end
        end
        S_DRAIN: begin
          if (all_idle) begin
            lev   <= cnt - LEV_W'(1);
            state <= S_READ;
          end
        end
        S_READ: begin
          ang   <= '0;
          state <= S_UP;
        end
        S_UP: begin
          ang <= ang + ANG_W'(1);
          if (ang == ANG_W'(NUM_ANGLES - 1)) begin
            if (lev == '0) begin
              state <= S_TAIL;
            end else begin
              lev   <= lev - LEV_W'(1);
              state <= S_READ;
            end
          end
        end
        S_TAIL: begin
          if (all_idle) begin
            cnt     <= '0;
            dropped <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// layer columns with directed extremes, capacity overflow and random content
// are sent to the solver; a built-in flux predictor queues the expected
// level results, and each strobed result is compared field by field
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lss_pkg::*;

  typedef struct {
    logic [6:0]  lev;
    logic [31:0] dn;
    logic [31:0] up;
    logic        fin;
    logic        ovf;
  } level_flux_t;

  localparam int STALL_LIMIT = 20000;
  localparam logic [63:0] PI_Q = 64'd205887;
  localparam logic [63:0] E_NEG [12] = '{
    64'd65536, 64'd24109, 64'd8869, 64'd3263, 64'd1200, 64'd442,
    64'd162, 64'd60, 64'd22, 64'd8, 64'd3, 64'd1
  };

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [23:0] layer_tau;
  logic [31:0] layer_source;
  logic [31:0] surface_source;
  logic        bottom;
  logic        strobe;
  logic [6:0]  level;
  logic [31:0] down_flux;
  logic [31:0] up_flux;
  logic        final_level;
  logic        overflow;

  longwave_schwarzschild_solver u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .layer_tau(layer_tau), .layer_source(layer_source),
    .surface_source(surface_source), .bottom(bottom),
    .strobe(strobe), .level(level), .down_flux(down_flux),
    .up_flux(up_flux), .final_level(final_level), .overflow(overflow)
  );

  // predictor state
  logic [31:0] rad_dn [NUM_ANGLES];
  logic [23:0] col_tau [MAX_LAYERS];
  logic [31:0] col_src [MAX_LAYERS];
  logic [31:0] col_dflux [MAX_LAYERS+1];
  int          col_count;
  logic        col_dropped;

  level_flux_t flux_q [$];
  int          errors;
  int          layers_sent;
  int          columns_done;
  int          levels_seen;
  int          overflow_cols;
  int          stall;
  bit          quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] transmission(logic [23:0] tau, int i);
    logic [63:0] x, n, f, p;
    x = (64'(tau) * 64'd40) / 64'(2 * i + 1);
    n = x >> 16;
    f = x & 64'hFFFF;
    p = 64'd65536;
    if (n >= 12) return 64'd0;
    for (int k = 8; k >= 1; k--) p = 64'd65536 - (f * p) / (64'(k) << 16);
    return (E_NEG[n] * p + 64'd32768) >> 16;
  endfunction

  function automatic logic [31:0] mix(logic [31:0] l, logic [31:0] b,
                                      logic [23:0] tau, int i);
    logic [63:0] t;
    t = transmission(tau, i);
    return 32'((t * 64'(l) + (64'd65536 - t) * 64'(b) + 64'd32768) >> 16);
  endfunction

  function automatic logic [31:0] irradiance(logic [31:0] r [NUM_ANGLES]);
    logic [63:0] s, e;
    s = 0;
    for (int i = 0; i < NUM_ANGLES; i++) s += 64'(r[i]) * 64'(2 * i + 1);
    e = ((s * PI_Q) / 64'(NUM_ANGLES * NUM_ANGLES) + 64'd32768) >> 16;
    return (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(e);
  endfunction

  task automatic predict_layer(logic [23:0] tau, logic [31:0] src,
                               logic [31:0] bs, logic bot);
    logic [31:0] rad_up [NUM_ANGLES];
    logic [63:0] e;
    level_flux_t r;
    if (col_count < MAX_LAYERS) begin
      col_tau[col_count] = tau;
      col_src[col_count] = src;
      for (int i = 0; i < NUM_ANGLES; i++) rad_dn[i] = mix(rad_dn[i], src, tau, i);
      col_count++;
      col_dflux[col_count] = irradiance(rad_dn);
    end else begin
      col_dropped = 1'b1;
    end
    if (!bot) return;
    col_dflux[0] = 0;
    for (int i = 0; i < NUM_ANGLES; i++) rad_up[i] = bs;
    e = (64'(bs) * PI_Q + 64'd32768) >> 16;
    for (int lv = col_count; lv >= 0; lv--) begin
      if (lv < col_count) begin
        for (int i = 0; i < NUM_ANGLES; i++)
          rad_up[i] = mix(rad_up[i], col_src[lv], col_tau[lv], i);
        e = irradiance(rad_up);
      end
      r.lev = 7'(lv);
      r.dn  = col_dflux[lv];
      r.up  = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(e);
      r.fin = (lv == 0);
      r.ovf = col_dropped;
      flux_q.push_back(r);
    end
    if (col_dropped) overflow_cols++;
    for (int i = 0; i < NUM_ANGLES; i++) rad_dn[i] = 0;
    col_count   = 0;
    col_dropped = 1'b0;
    columns_done++;
  endtask

  // one beat, held until accepted
  task automatic send_layer(logic [23:0] tau, logic [31:0] src,
                            logic [31:0] bs, logic bot);
    if (!quiet) begin
      while ($urandom_range(99) < 9) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start          <= 1'b1;
    layer_tau      <= tau;
    layer_source   <= src;
    surface_source <= bs;
    bottom         <= bot;
    do @(posedge clk); while (busy);
    predict_layer(tau, src, bs, bot);
    layers_sent++;
  endtask

  function automatic logic [23:0] rand_tau();
    case ($urandom_range(3))
      0: return 24'($urandom_range(0, 24'h00FFFF));
      1: return 24'($urandom_range(0, 24'h03FFFF));
      2: return 24'($urandom);
      default: return $urandom_range(1) ? 24'hFFFFFF : 24'h0;
    endcase
  endfunction

  function automatic logic [31:0] rand_src();
    case ($urandom_range(3))
      0: return 32'hFFFF_FFFF;
      1: return $urandom_range(0, 32'h0FFF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    send_layer(24'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_layer(24'hFFFFFF, 32'hFFFF_FFFF, 32'h0, 1'b1);
    send_layer(24'h000001, 32'h0, 32'h0, 1'b1);
    send_layer(24'hFFFFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0);
    send_layer(24'h0, 32'h0, 32'h5555_5555, 1'b0);
    send_layer(24'h010000, 32'h0010_0000, 32'h0010_0000, 1'b1);
    send_layer(24'h00C000, 32'h5555_5555, 32'h0, 1'b0);
    send_layer(24'h000200, 32'hAAAA_AAAA, 32'h0, 1'b0);
    send_layer(24'h0C0000, 32'h1234_5678, 32'h0, 1'b0);
    send_layer(24'h555555, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_layer(24'hAAAAAA, 32'h0, 32'h8000_0000, 1'b1);
  endtask

  task automatic test_capacity();
    for (int k = 0; k < MAX_LAYERS; k++)
      send_layer(rand_tau(), rand_src(), $urandom, k == MAX_LAYERS - 1);
    for (int k = 0; k < MAX_LAYERS + 1; k++)
      send_layer(24'($urandom_range(0, 24'h00FFFF)), rand_src(), $urandom, k == MAX_LAYERS);
    for (int k = 0; k < MAX_LAYERS + 4; k++)
      send_layer(rand_tau(), rand_src(), $urandom, k == MAX_LAYERS + 3);
  endtask

  task automatic test_random_columns(int n_layers);
    int depth;
    while (n_layers > 0) begin
      quiet = ($urandom_range(9) == 0);
      depth = ($urandom_range(9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      for (int k = 0; k < depth; k++)
        send_layer(rand_tau(), rand_src(), rand_src(), k == depth - 1);
      n_layers -= depth;
    end
    quiet = 1'b0;
  endtask

  task automatic test_no_idle_stretch();
    quiet = 1'b1;
    for (int c = 0; c < 6; c++)
      for (int k = 0; k < 4; k++)
        send_layer(rand_tau(), rand_src(), rand_src(), k == 3);
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    level_flux_t x;
    if (!rst && strobe) begin
      levels_seen++;
      if (flux_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected level beat, level %0d", $time, level);
      end else begin
        x = flux_q.pop_front();
        if (level !== x.lev || down_flux !== x.dn || up_flux !== x.up ||
            final_level !== x.fin || overflow !== x.ovf) begin
          errors++;
          $display("%0t: mismatch exp lev=%0d dn=%h up=%h fin=%b ovf=%b", $time,
                   x.lev, x.dn, x.up, x.fin, x.ovf);
          $display("%0t:          got lev=%0d dn=%h up=%h fin=%b ovf=%b", $time,
                   level, down_flux, up_flux, final_level, overflow);
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat and no strobed result
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) stall <= 0;
    else stall <= stall + 1;
    if (stall >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    layer_tau = '0;
    layer_source = '0;
    surface_source = '0;
    bottom = 1'b0;
    errors = 0;
    layers_sent = 0;
    columns_done = 0;
    levels_seen = 0;
    overflow_cols = 0;
    stall = 0;
    quiet = 1'b0;
    col_count = 0;
    col_dropped = 1'b0;
    for (int i = 0; i < NUM_ANGLES; i++) rad_dn[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_capacity();
    test_no_idle_stretch();
    test_random_columns(140);
    start <= 1'b0;
    while (flux_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d layers in %0d columns (%0d over capacity), %0d level results checked",
             layers_sent, columns_done, overflow_cols, levels_seen);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
